@@ rtl/mue_pkg.sv @@
// Shared types and constants for the mesh unique edge extractor.
`default_nettype none

package mue_pkg;

    localparam int EDGES_PER_FACE = 3;
    localparam int PHASE_BITS     = 2;

    typedef enum logic [1:0]
    {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed
    {
        logic lt;
        logic eq;
    } cell_stat_t;

endpackage

`default_nettype wire

@@ rtl/mue_cell.sv @@
// One slot of the sorted edge chain: holds a key, compares, inserts or shifts.
`default_nettype none

module mue_cell
#(
    parameter int KEY_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire mue_pkg::cell_op_t     op,
    input  wire logic                  occ,
    input  wire logic [KEY_BITS-1:0]   new_key,
    input  wire logic [KEY_BITS-1:0]   prev_key,
    input  wire logic                  prev_lt,
    input  wire logic [KEY_BITS-1:0]   next_key,
    output logic [KEY_BITS-1:0]        key,
    output mue_pkg::cell_stat_t        stat
);
    import mue_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    assign stat.lt = occ && (key_reg < new_key);
    assign stat.eq = occ && (key_reg == new_key);
    assign key     = key_reg;

    always_comb
    begin
        key_next = key_reg;
        case (op)
            CELL_INSERT:
            begin
                if (!stat.lt)
                begin
                    key_next = prev_lt ? new_key : prev_key;
                end
            end
            CELL_SHIFT:
            begin
                key_next = next_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

@@ rtl/mesh_unique_edge_extractor.sv @@
// One edge per cycle goes to the cell chain, which skips duplicates and inserts none when full.
// A new face can be taken during its predecessor's last edge, unless that face ended its mesh.
// After the last face, up to MAX_EDGES results leave the head cell, one per unstalled cycle.
// A new face is taken once the final result has been taken.
// Reset clears control state, the edge count and the overflow flag; cells need no clear.
`default_nettype none

module mesh_unique_edge_extractor
#(
    parameter int MAX_EDGES   = 64,
    parameter int VERTEX_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        face_valid,
    output logic             face_stall,
    input  wire logic [15:0] first_vertex,
    input  wire logic [15:0] second_vertex,
    input  wire logic [15:0] third_vertex,
    input  wire logic        last_face,
    output logic             edge_valid,
    input  wire logic        edge_stall,
    output logic [15:0]      edge_low,
    output logic [15:0]      edge_high,
    output logic             overflow,
    output logic             last_edge
);
    import mue_pkg::*;

    localparam int KEY_BITS = 2 * VERTEX_BITS;
    localparam int CW       = $clog2(MAX_EDGES + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_INSERT,
        S_DRAIN
    } state_t;

    state_t                  state_reg;
    logic [PHASE_BITS-1:0]   phase_reg;
    logic [CW-1:0]           count_reg;
    logic                    ovf_reg;
    logic                    last_reg;
    logic [VERTEX_BITS-1:0]  v0_reg;
    logic [VERTEX_BITS-1:0]  v1_reg;
    logic [VERTEX_BITS-1:0]  v2_reg;

    logic [VERTEX_BITS-1:0]  va;
    logic [VERTEX_BITS-1:0]  vb;
    logic [KEY_BITS-1:0]     new_key;
    logic                    dup;
    logic                    full;
    logic                    face_acc;
    logic                    edge_acc;
    logic                    phase_end;
    cell_op_t                op;

    logic [KEY_BITS-1:0]     key_w  [MAX_EDGES];
    cell_stat_t              stat_w [MAX_EDGES];
    logic [MAX_EDGES-1:0]    eq_vec;

    assign phase_end  = (phase_reg == PHASE_BITS'(EDGES_PER_FACE - 1));
    assign face_stall = !((state_reg == S_IDLE) ||
                          ((state_reg == S_INSERT) && phase_end && !last_reg));
    assign face_acc   = face_valid && !face_stall;
    assign edge_valid = (state_reg == S_DRAIN);
    assign edge_acc   = edge_valid && !edge_stall;

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                va = v0_reg;
                vb = v1_reg;
            end
            2'd1:
            begin
                va = v1_reg;
                vb = v2_reg;
            end
            default:
            begin
                va = v2_reg;
                vb = v0_reg;
            end
        endcase
    end

    assign new_key = (va < vb) ? {va, vb} : {vb, va};
    assign dup     = |eq_vec;
    assign full    = (count_reg == CW'(MAX_EDGES));

    always_comb
    begin
        op = CELL_HOLD;
        if ((state_reg == S_INSERT) && !dup && !full)
        begin
            op = CELL_INSERT;
        end
        else if (edge_acc)
        begin
            op = CELL_SHIFT;
        end
    end

    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic                prev_lt;
        logic [KEY_BITS-1:0] next_key;

        if (i == 0)
        begin : g_head
            assign prev_key = new_key;
            assign prev_lt  = 1'b1;
        end
        else
        begin : g_body
            assign prev_key = key_w[i-1];
            assign prev_lt  = stat_w[i-1].lt;
        end

        if (i == MAX_EDGES - 1)
        begin : g_tail
            assign next_key = key_w[i];
        end
        else
        begin : g_mid
            assign next_key = key_w[i+1];
        end

        mue_cell #(.KEY_BITS(KEY_BITS)) u_cell
        (
            .clk      (clk),
            .op       (op),
            .occ      (CW'(i) < count_reg),
            .new_key  (new_key),
            .prev_key (prev_key),
            .prev_lt  (prev_lt),
            .next_key (next_key),
            .key      (key_w[i]),
            .stat     (stat_w[i])
        );

        assign eq_vec[i] = stat_w[i].eq;
    end

    assign edge_low  = 16'(key_w[0][KEY_BITS-1:VERTEX_BITS]);
    assign edge_high = 16'(key_w[0][VERTEX_BITS-1:0]);
    assign overflow  = ovf_reg;
    assign last_edge = (count_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (face_acc)
                    begin
                        state_reg <= S_INSERT;
                        phase_reg <= '0;
                    end
                end
                S_INSERT:
                begin
                    if (!dup)
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    if (phase_end)
                    begin
                        phase_reg <= '0;
                        if (last_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else if (!face_acc)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + PHASE_BITS'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (edge_acc)
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            state_reg <= S_IDLE;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (face_acc)
            begin
                last_reg <= last_face;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (face_acc)
        begin
            v0_reg <= VERTEX_BITS'(first_vertex);
            v1_reg <= VERTEX_BITS'(second_vertex);
            v2_reg <= VERTEX_BITS'(third_vertex);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EDGES))
        else $error("edge count above capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid |-> (count_reg != '0))
        else $error("result request with empty chain");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && (state_reg == S_INSERT)) |-> full)
        else $error("overflow flagged while chain not full");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (key_w[0] < key_w[1]))
        else $error("chain head out of order");

endmodule

`default_nettype wire

@@ verif/edge_list_checker.sv @@
// Predicts the sorted unique edge list of each mesh and compares it with the edges leaving the block.
module edge_list_checker
#(
    parameter int MAX_EDGES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        face_valid,
    input  wire logic        face_stall,
    input  wire logic [15:0] first_vertex,
    input  wire logic [15:0] second_vertex,
    input  wire logic [15:0] third_vertex,
    input  wire logic        last_face,
    input  wire logic        edge_valid,
    input  wire logic        edge_stall,
    input  wire logic [15:0] edge_low,
    input  wire logic [15:0] edge_high,
    input  wire logic        overflow,
    input  wire logic        last_edge,
    output int               mismatches,
    output int               pending_edges,
    output int               edges_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [15:0] lo;
        logic [15:0] hi;
        logic        ovf;
        logic        fin;
    } edge_res_t;

    logic [31:0] edge_set[$];
    bit          edges_dropped;
    edge_res_t   expected_edges[$];

    function automatic void add_edge(logic [15:0] a, logic [15:0] b);
        logic [31:0] key;
        int          pos;
        key = (a < b) ? {a, b} : {b, a};
        pos = 0;
        while (pos < edge_set.size() && edge_set[pos] < key)
            pos++;
        if (pos < edge_set.size() && edge_set[pos] == key)
            return;
        if (edge_set.size() >= MAX_EDGES)
        begin
            edges_dropped = 1'b1;
            return;
        end
        edge_set.insert(pos, key);
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : watch
        edge_res_t want;
        edge_res_t got;
        int        k;
        if (rst_n)
        begin
            if (edge_valid && !edge_stall)
            begin
                got = '{edge_low, edge_high, overflow, last_edge};
                edges_checked++;
                if (expected_edges.size() == 0)
                    note_failure($sformatf("unexpected edge low=%h high=%h ovf=%b last=%b",
                                           got.lo, got.hi, got.ovf, got.fin));
                else
                begin
                    want = expected_edges.pop_front();
                    if (got.lo !== want.lo || got.hi !== want.hi ||
                        got.ovf !== want.ovf || got.fin !== want.fin)
                        note_failure($sformatf({"edge mismatch: expected low=%h high=%h ",
                                                "ovf=%b last=%b, got low=%h high=%h ",
                                                "ovf=%b last=%b"},
                                               want.lo, want.hi, want.ovf, want.fin,
                                               got.lo, got.hi, got.ovf, got.fin));
                end
            end
            if (face_valid && !face_stall)
            begin
                add_edge(first_vertex, second_vertex);
                add_edge(second_vertex, third_vertex);
                add_edge(third_vertex, first_vertex);
                if (last_face)
                begin
                    for (k = 0; k < edge_set.size(); k++)
                        expected_edges.push_back('{edge_set[k][31:16], edge_set[k][15:0],
                                                   edges_dropped,
                                                   k == edge_set.size() - 1});
                    edge_set.delete();
                    edges_dropped = 1'b0;
                end
            end
            pending_edges = expected_edges.size();
        end
    end
endmodule

@@ verif/tb_top.sv @@
// Top of the edge extractor testbench: clock, reset, face requests, edge backpressure, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EDGES   = 64;
    localparam int FACE_TARGET = 350;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        face_valid    = 1'b0;
    logic [15:0] first_vertex  = '0;
    logic [15:0] second_vertex = '0;
    logic [15:0] third_vertex  = '0;
    logic        last_face     = 1'b0;
    logic        edge_stall    = 1'b0;
    wire logic        face_stall;
    wire logic        edge_valid;
    wire logic [15:0] edge_low;
    wire logic [15:0] edge_high;
    wire logic        overflow;
    wire logic        last_edge;

    int mismatches;
    int pending_edges;
    int edges_checked;
    int cycles       = 0;
    int faces_sent   = 0;
    int meshes_sent  = 0;
    int large_meshes = 0;
    int stall_left   = 0;
    bit calm         = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mesh_unique_edge_extractor #(.MAX_EDGES(MAX_EDGES), .VERTEX_BITS(16)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .face_valid    (face_valid),
        .face_stall    (face_stall),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .last_face     (last_face),
        .edge_valid    (edge_valid),
        .edge_stall    (edge_stall),
        .edge_low      (edge_low),
        .edge_high     (edge_high),
        .overflow      (overflow),
        .last_edge     (last_edge)
    );

    edge_list_checker #(.MAX_EDGES(MAX_EDGES)) u_edge_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .face_valid    (face_valid),
        .face_stall    (face_stall),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .last_face     (last_face),
        .edge_valid    (edge_valid),
        .edge_stall    (edge_stall),
        .edge_low      (edge_low),
        .edge_high     (edge_high),
        .overflow      (overflow),
        .last_edge     (last_edge),
        .mismatches    (mismatches),
        .pending_edges (pending_edges),
        .edges_checked (edges_checked)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d edges still pending", cycles, pending_edges);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: fresh stall length drawn after every taken edge
    always @(posedge clk)
    begin
        if (edge_valid && !edge_stall)
        begin
            stall_left = calm ? 0 : $urandom_range(0, 8);
            edge_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            edge_stall <= (stall_left != 0);
        end
    end

    task automatic send_face(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            face_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        face_valid    <= 1'b1;
        first_vertex  <= a;
        second_vertex <= b;
        third_vertex  <= c;
        last_face     <= fin;
        @(posedge clk);
        while (face_stall)
            @(posedge clk);
        faces_sent++;
    endtask

    task automatic drain_edges();
        face_valid <= 1'b0;
        @(posedge clk);
        while (pending_edges != 0)
            @(posedge clk);
    endtask

    task automatic send_mesh();
        int          mode;
        int          nfaces;
        int          k;
        logic [15:0] base;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        mode = $urandom_range(0, 19);
        base = 16'($urandom);
        if (mode >= 18)
        begin
            nfaces = $urandom_range(22, 26);
            large_meshes++;
        end
        else
            nfaces = $urandom_range(1, 8);
        for (k = 0; k < nfaces; k++)
        begin
            if (mode < 10)
            begin
                // narrow vertex pool so shared edges are common
                a = 16'(base + $urandom_range(0, 7));
                b = 16'(base + $urandom_range(0, 7));
                c = 16'(base + $urandom_range(0, 7));
            end
            else if (mode < 15 || mode >= 18)
            begin
                a = 16'($urandom);
                b = 16'($urandom);
                c = 16'($urandom);
            end
            else
            begin
                a = 16'(base + $urandom_range(0, 3));
                b = $urandom_range(0, 1) ? a : 16'(base + $urandom_range(0, 3));
                c = $urandom_range(0, 1) ? b : 16'(base + $urandom_range(0, 3));
            end
            send_face(a, b, c, k == nfaces - 1);
        end
        meshes_sent++;
    endtask

    initial
    begin : stimulus
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_face(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_face(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        send_face(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        // 63 distinct edges, then one fits and two drop, then a repeat while full
        for (k = 0; k < 21; k++)
            send_face(16'(3 * k), 16'(3 * k + 1), 16'(3 * k + 2), 1'b0);
        send_face(16'd60000, 16'd60001, 16'd60002, 1'b0);
        send_face(16'd0, 16'd1, 16'd2, 1'b1);
        meshes_sent = 3;
        drain_edges();

        while (faces_sent < FACE_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            send_mesh();
            if ($urandom_range(0, 3) == 0)
                drain_edges();
        end
        drain_edges();
        calm = 1'b0;
        repeat (4 * mue_pkg::EDGES_PER_FACE) @(posedge clk);

        $display("Covered %0d faces in %0d meshes (%0d large enough to fill the store)",
                 faces_sent, meshes_sent, large_meshes);
        $display("Checked %0d edges, %0d mismatches", edges_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/mue_pkg.sv
rtl/mue_cell.sv
rtl/mesh_unique_edge_extractor.sv
verif/edge_list_checker.sv
verif/tb_top.sv
